// ===== design/fnvsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fnvsm_pkg
// Shared types and constants for the FNV-1a / splitmix64 noise hash block.
// ----------------------------------------------------------------------------
package fnvsm_pkg;

  // Hash constants
  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] MIX_K1    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_K2    = 64'h94D049BB133111EB;

  // Date packing and amplitude
  localparam int unsigned PACK_W      = 28;
  localparam int unsigned YEAR_SCALE  = 10000;
  localparam int unsigned MONTH_SCALE = 100;
  localparam logic [16:0] AMP_ONE     = 17'd65536;

  // Input command codes
  localparam logic [1:0] CMD_EVENT   = 2'd0;
  localparam logic [1:0] CMD_COUNTRY = 2'd1;
  localparam logic [1:0] CMD_FINISH  = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_EMPTY_EVENT   = 3'd1;
  localparam logic [2:0] ST_EMPTY_COUNTRY = 3'd2;
  localparam logic [2:0] ST_AMP_RANGE     = 3'd3;
  localparam logic [2:0] ST_ORDER         = 3'd4;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_FOLD_IN,
    DP_FOLD_ZERO,
    DP_FOLD_REG,
    DP_FOLD_PACK,
    DP_XS30,
    DP_XS27,
    DP_XS31,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_MUL3,
    DP_NOISE
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_t     op;
    logic       ksel;      // 0: first mix constant, 1: second
    logic       capture;   // latch byte, date and amplitude of the input word
    logic       load_out;  // load the result registers
    logic       clear;     // return the running hash to the basis
    logic [2:0] code;      // status of the result being loaded
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic amp_over;        // input amplitude above 1.0
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== design/fnv1a_splitmix_noise_hash.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fnv1a_splitmix_noise_hash
// FNV-1a 64 hash of event and country strings and a date, finished with the
// splitmix64 mixer, giving the hash and a signed Q.31 noise sample.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            word
//   in       input      in_valid / in_ready  cmd, byte_value, year, month,
//                                            day, amplitude
//   out      output     out_valid/out_ready  status, noise, hash_value
//
// An in-order string byte is folded as it is accepted; the first country
// byte first folds the zero separator, then the byte itself in its own state,
// while input is not ready. A finish word runs these steps before the next
// word is accepted: eight date folds, three xorshift steps, two 64-bit
// multiplies on the shared 32x32 multiplier, one noise multiply and one
// result load. The result load waits while an earlier result is still held
// on the output. Reset clears the running hash to the FNV basis and all
// flags; no result is pending.
module fnv1a_splitmix_noise_hash
  import fnvsm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    cmd,
  input  wire logic [7:0]    byte_value,
  input  wire logic [13:0]   year,
  input  wire logic [3:0]    month,
  input  wire logic [4:0]    day,
  input  wire logic [16:0]   amplitude,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] noise,
  output logic [63:0]        hash_value
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  fnvsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  fnvsm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .byte_value (byte_value),
    .year       (year),
    .month      (month),
    .day        (day),
    .amplitude  (amplitude),
    .status     (status),
    .noise      (noise),
    .hash_value (hash_value)
  );

endmodule
`default_nettype wire

// ===== design/fnvsm_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fnvsm_dp
// Datapath: running FNV-1a hash, date packing, shared 32x32 multiplier for
// the splitmix64 finalizer, noise scaling and the result registers.
// ----------------------------------------------------------------------------
module fnvsm_dp
  import fnvsm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             ctl,
  output dp_stat_t                 stat,
  input  wire logic [7:0]          byte_value,
  input  wire logic [13:0]         year,
  input  wire logic [3:0]          month,
  input  wire logic [4:0]          day,
  input  wire logic [16:0]         amplitude,
  output logic [2:0]               status,
  output logic signed [31:0]       noise,
  output logic [63:0]              hash_value
);

  logic [63:0]        h;
  logic [63:0]        h_next;
  logic [7:0]         byte_reg;
  logic [PACK_W-1:0]  pack;
  logic [PACK_W-1:0]  pack_in;
  logic [16:0]        amp;
  logic [63:0]        prod;
  logic [31:0]        lo;
  logic [31:0]        hi;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        kmix;
  logic [7:0]         fold_b;
  logic [63:0]        fx;
  logic [63:0]        folded;
  logic signed [49:0] nprod;
  logic signed [31:0] centered;

  assign stat.amp_over = (amplitude > AMP_ONE);

  // Pack the date as year*10000 + month*100 + day
  assign pack_in = PACK_W'(year) * PACK_W'(YEAR_SCALE)
                 + PACK_W'(month) * PACK_W'(MONTH_SCALE)
                 + PACK_W'(day);

  // Pick the byte to fold
  always_comb begin
    case (ctl.op)
      DP_FOLD_IN:   fold_b = byte_value;
      DP_FOLD_REG:  fold_b = byte_reg;
      DP_FOLD_PACK: fold_b = pack[7:0];
      default:      fold_b = 8'd0;
    endcase
  end

  // FNV-1a step; the prime is 2^40 + 0x1b3, so the multiply is shift-add
  assign fx = h ^ {56'd0, fold_b};
  assign folded = (fx << 40) + (fx << 8) + (fx << 7) + (fx << 5)
                + (fx << 4) + (fx << 1) + fx;

  // Shared multiplier operands: low 64 bits of h * k from three partials
  assign kmix  = ctl.ksel ? MIX_K2 : MIX_K1;
  assign mul_a = (ctl.op == DP_MUL1) ? h[63:32] : h[31:0];
  assign mul_b = (ctl.op == DP_MUL2) ? kmix[63:32] : kmix[31:0];

  // Offset the top half by 2^31 to get a signed sample
  assign centered = $signed({~h[63], h[62:32]});

  // Next running hash
  always_comb begin
    case (ctl.op)
      DP_FOLD_IN,
      DP_FOLD_ZERO,
      DP_FOLD_REG,
      DP_FOLD_PACK: h_next = folded;
      DP_XS30:      h_next = h ^ (h >> 30);
      DP_XS27:      h_next = h ^ (h >> 27);
      DP_XS31:      h_next = h ^ (h >> 31);
      DP_MUL3:      h_next = {hi + prod[31:0], lo};
      default:      h_next = h;
    endcase
  end

  // Hold the running hash
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      h <= FNV_BASIS;
    end else begin
      h <= h_next;
    end
  end

  // Capture, multiply, accumulate and load results
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      byte_reg <= byte_value;
      pack     <= pack_in;
      amp      <= amplitude;
    end else if (ctl.op == DP_FOLD_PACK) begin
      pack <= pack >> 8;
    end
    prod <= {32'd0, mul_a} * {32'd0, mul_b};
    if (ctl.op == DP_MUL1) begin
      lo <= prod[31:0];
      hi <= prod[63:32];
    end else if (ctl.op == DP_MUL2) begin
      hi <= hi + prod[31:0];
    end
    if (ctl.op == DP_NOISE) begin
      nprod <= 50'(centered) * 50'($signed({1'b0, amp}));
    end
    if (ctl.load_out) begin
      status <= ctl.code;
      if (ctl.code == ST_OK) begin
        hash_value <= h;
        noise      <= nprod[47:16];
      end else begin
        hash_value <= 64'd0;
        noise      <= 32'sd0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/fnvsm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fnvsm_ctrl
// Controller: accepts input words, tracks string order flags, sequences the
// date fold, finalizer and noise steps, and owns the output handshake.
// ----------------------------------------------------------------------------
module fnvsm_ctrl
  import fnvsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] cmd,
  output logic            out_valid,
  input  wire logic       out_ready,
  output dp_cmd_t         ctl,
  input  wire dp_stat_t   stat
);

  typedef enum logic [4:0] {
    S_IDLE, S_SEP, S_DATE, S_XS_A,
    S_MA0, S_MA1, S_MA2, S_MA3, S_XS_B,
    S_MB0, S_MB1, S_MB2, S_MB3, S_XS_C,
    S_NOISE, S_OUT
  } state_t;

  state_t     state;
  state_t     state_next;
  logic       saw_event;
  logic       saw_country;
  logic       order_fault;
  logic [2:0] code;
  logic [2:0] code_next;
  logic [2:0] cnt;
  logic       accept;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // Status of a finish word, lowest error code first; OK when none applies
  always_comb begin
    if (!saw_event) begin
      code_next = ST_EMPTY_EVENT;
    end else if (!saw_country) begin
      code_next = ST_EMPTY_COUNTRY;
    end else if (stat.amp_over) begin
      code_next = ST_AMP_RANGE;
    end else if (order_fault) begin
      code_next = ST_ORDER;
    end else begin
      code_next = ST_OK;
    end
  end

  // Decode commands and next state
  always_comb begin
    ctl          = '0;
    ctl.op       = DP_NOP;
    ctl.code     = code;
    state_next   = state;
    case (state)
      S_IDLE: begin
        ctl.capture = accept;
        if (accept) begin
          case (cmd)
            CMD_EVENT: begin
              if (!saw_country) ctl.op = DP_FOLD_IN;
            end
            CMD_COUNTRY: begin
              if (saw_country) begin
                ctl.op = DP_FOLD_IN;
              end else begin
                ctl.op     = DP_FOLD_ZERO;
                state_next = S_SEP;
              end
            end
            CMD_FINISH: state_next = S_DATE;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SEP:   begin ctl.op = DP_FOLD_REG;  state_next = S_IDLE; end
      S_DATE: begin
        ctl.op = DP_FOLD_PACK;
        if (cnt == 3'd7) state_next = S_XS_A;
      end
      S_XS_A:  begin ctl.op = DP_XS30; state_next = S_MA0; end
      S_MA0:   begin ctl.op = DP_MUL0; state_next = S_MA1; end
      S_MA1:   begin ctl.op = DP_MUL1; state_next = S_MA2; end
      S_MA2:   begin ctl.op = DP_MUL2; state_next = S_MA3; end
      S_MA3:   begin ctl.op = DP_MUL3; state_next = S_XS_B; end
      S_XS_B:  begin ctl.op = DP_XS27; state_next = S_MB0; end
      S_MB0:   begin ctl.op = DP_MUL0; ctl.ksel = 1'b1; state_next = S_MB1; end
      S_MB1:   begin ctl.op = DP_MUL1; ctl.ksel = 1'b1; state_next = S_MB2; end
      S_MB2:   begin ctl.op = DP_MUL2; ctl.ksel = 1'b1; state_next = S_MB3; end
      S_MB3:   begin ctl.op = DP_MUL3; ctl.ksel = 1'b1; state_next = S_XS_C; end
      S_XS_C:  begin ctl.op = DP_XS31; state_next = S_NOISE; end
      S_NOISE: begin ctl.op = DP_NOISE; state_next = S_OUT; end
      S_OUT: begin
        if (slot_free) begin
          ctl.load_out = 1'b1;
          ctl.clear    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state, flags and the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      saw_event   <= 1'b0;
      saw_country <= 1'b0;
      order_fault <= 1'b0;
      out_valid   <= 1'b0;
      code        <= ST_OK;
      cnt         <= 3'd0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (cmd)
          CMD_EVENT: begin
            if (saw_country) order_fault <= 1'b1;
            else saw_event <= 1'b1;
          end
          CMD_COUNTRY: saw_country <= 1'b1;
          CMD_FINISH: begin
            code <= code_next;
            cnt  <= 3'd0;
          end
          default: cnt <= cnt;
        endcase
      end
      if (state == S_DATE) cnt <= cnt + 3'd1;
      // Drop the word once taken, raise it on a new result
      if (ctl.load_out) begin
        out_valid   <= 1'b1;
        saw_event   <= 1'b0;
        saw_country <= 1'b0;
        order_fault <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
